[src/etg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etg_pkg
// Shared types and codes of the eased tween generator.
// ----------------------------------------------------------------------------
package etg_pkg;

   // width of the interpolated value and of the value registers
   localparam int VALUE_BITS = 16;
   localparam int DUR_BITS   = 16;
   localparam int TIME_BITS  = 32;

   // request opcodes
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_PLAY   = 3'd1;
   localparam logic [2:0] OP_STOP   = 3'd2;
   localparam logic [2:0] OP_PAUSE  = 3'd3;
   localparam logic [2:0] OP_RESUME = 3'd4;

   // run states
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PLAY  = 2'd1;
   localparam logic [1:0] PH_PAUSE = 2'd2;

   // easing curves
   localparam logic [2:0] EASE_LINEAR = 3'd0;
   localparam logic [2:0] EASE_IN     = 3'd1;
   localparam logic [2:0] EASE_OUT    = 3'd2;
   localparam logic [2:0] EASE_BOTH   = 3'd3;
   localparam logic [2:0] EASE_CONST  = 3'd4;

   // tween modes
   localparam logic [1:0] MODE_ONCE     = 2'd0;
   localparam logic [1:0] MODE_REV_ONCE = 2'd1;
   localparam logic [1:0] MODE_LOOP     = 2'd2;
   localparam logic [1:0] MODE_FLIP     = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_VALUE_START = 3'd0;
   localparam logic [2:0] CSR_VALUE_END   = 3'd1;
   localparam logic [2:0] CSR_DURATION    = 3'd2;
   localparam logic [2:0] CSR_EASING      = 3'd3;
   localparam logic [2:0] CSR_MODE        = 3'd4;

   localparam logic [DUR_BITS-1:0] DURATION_RESET = 16'd1000;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [TIME_BITS-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] current_value;
      logic [1:0]                   run_state;
      logic                         finished;
      logic                         reversed;
   } rsp_payload_type;

   // command to the progress divider
   typedef struct packed {
      logic                start;
      logic [DUR_BITS-1:0] dividend;
      logic [DUR_BITS-1:0] divisor;
   } div_cmd_type;

endpackage

[src/etg_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etg_divider
// Restoring divider, one quotient bit per cycle: (dividend << FRAC_BITS) /
// divisor for dividend <= divisor, quotient in FRAC_BITS + 1 bits.
// ----------------------------------------------------------------------------
module etg_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  etg_pkg::div_cmd_type cmd,
   output logic                 done,
   output logic [FRAC_BITS:0]   quotient
);
   import etg_pkg::*;

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [DUR_BITS:0]     rem_ff;
   logic [DUR_BITS:0]     rem_in;
   logic [DUR_BITS-1:0]   divisor_ff;
   logic [FRAC_BITS:0]    quo_ff;
   logic                  ge;

   // trial subtract of the divisor from the partial remainder
   always_comb begin
      ge     = rem_ff >= {1'b0, divisor_ff};
      rem_in = ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath: remainder shifts left, quotient bits shift in from the right
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= {1'b0, cmd.dividend};
         divisor_ff <= cmd.divisor;
         cnt_ff     <= CNT_BITS'(FRAC_BITS);
         quo_ff     <= '0;
      end else if (busy_ff) begin
         rem_ff <= {rem_in[DUR_BITS-1:0], 1'b0};
         quo_ff <= {quo_ff[FRAC_BITS-1:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[src/etg_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etg_mul
// Shared signed multiplier with a registered product, used for the easing
// square and for the interpolation product.
// ----------------------------------------------------------------------------
module etg_mul #(
   parameter int WIDTH = 18
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [WIDTH-1:0]   a,
   input  logic signed [WIDTH-1:0]   b,
   output logic signed [2*WIDTH-1:0] product
);
   import etg_pkg::*;

   logic signed [2*WIDTH-1:0] product_ff;

   // product register loads only when the sequencer issues an operation
   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= a * b;
      end
   end

   assign product = product_ff;

endmodule

[src/eased_tween_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_tween_generator_top
// Tween generator: progress from elapsed time, easing curve, interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (opcode, now_ms) enter on req_valid/req_ready; one response
//   (current_value, run_state, finished, reversed) leaves per request on
//   rsp_valid/rsp_ready. Registers are written on csr_we with csr_addr and
//   csr_wdata; the user must write them only while the block is idle, as
//   the block does not enforce it. One request is worked on at a time;
//   req_ready is low while it runs. A tick while playing and inside the
//   pass runs the restoring divider, one progress bit per cycle, then the
//   shared multiplier twice (easing square, interpolation). A tick past
//   the pass end that keeps playing, or a tick with zero duration, skips
//   the divider; every other request goes straight to the response register.
//   req_ready returns as rsp_valid rises, once the response is loaded, so
//   the next request is accepted only after the previous response has
//   entered the output register.
//   The response sits in an output register; if the receiver stalls, the
//   next finished response waits until the register is taken.
//   Synchronous reset returns the block to idle with registers at defaults.
// ----------------------------------------------------------------------------
module eased_tween_generator_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  etg_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output etg_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic [2:0]               csr_addr,
   input  logic [15:0]              csr_wdata
);
   import etg_pkg::*;

   localparam int MW = (FRAC_BITS + 2 > VALUE_BITS + 2) ? FRAC_BITS + 2 : VALUE_BITS + 2;
   localparam int PW = 2 * MW;
   localparam logic [FRAC_BITS:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS:0] HALF_Q = ONE_Q >> 1;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SQ, S_EASE, S_LERP, S_SUM, S_DONE
   } state_type;

   state_type state_ff;

   // registers
   logic signed [VALUE_BITS-1:0] start_ff;
   logic signed [VALUE_BITS-1:0] end_ff;
   logic [DUR_BITS-1:0]          dur_ff;
   logic [2:0]                   easing_ff;
   logic [1:0]                   mode_ff;

   // tween state
   logic [1:0]                   phase_ff;
   logic                         flip_ff;
   logic [TIME_BITS-1:0]         pass_start_ff;
   logic [TIME_BITS-1:0]         pause_time_ff;
   logic signed [VALUE_BITS-1:0] held_ff;
   logic                         fin_ff;

   // datapath
   logic [FRAC_BITS:0]           p_ff;
   logic [FRAC_BITS:0]           e_ff;
   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_payload_ff;

   logic                         accept;
   logic [TIME_BITS-1:0]         elapsed;
   logic                         over;
   logic                         tick_play;
   logic                         tick_fin;
   state_type                    accept_state;
   div_cmd_type                  div_cmd;
   logic                         div_done;
   logic [FRAC_BITS:0]           div_quo;
   logic [FRAC_BITS:0]           p_mir;
   logic [FRAC_BITS:0]           q_mir;
   logic                         use_q;
   logic [FRAC_BITS:0]           sq_hi;
   logic [FRAC_BITS:0]           sq_lo;
   logic [FRAC_BITS:0]           eased;
   logic signed [VALUE_BITS:0]   delta;
   logic                         mul_en;
   logic signed [MW-1:0]         mul_a;
   logic signed [MW-1:0]         mul_b;
   logic signed [PW-1:0]         mul_p;
   logic signed [PW-1:0]         rnd;
   logic                         out_free;
   logic                         rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == S_DONE) && out_free;

   // elapsed time of the pass, wrapping
   assign elapsed = req_payload.now_ms - pass_start_ff;
   assign over    = elapsed > {{(TIME_BITS-DUR_BITS){1'b0}}, dur_ff};

   // where an accepted request goes first
   always_comb begin
      tick_play = (req_payload.opcode == OP_TICK) && (phase_ff == PH_PLAY);
      tick_fin  = tick_play && over && (mode_ff == MODE_ONCE || mode_ff == MODE_REV_ONCE);
      if (!tick_play || tick_fin) begin
         accept_state = S_DONE;
      end else if (over || dur_ff == '0) begin
         accept_state = S_SQ;
      end else begin
         accept_state = S_DIV;
      end
   end

   // divider launch for an in-pass tick with nonzero duration
   always_comb begin
      div_cmd.start    = accept && req_payload.opcode == OP_TICK && phase_ff == PH_PLAY
                         && !over && dur_ff != '0;
      div_cmd.dividend = elapsed[DUR_BITS-1:0];
      div_cmd.divisor  = dur_ff;
   end

   etg_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quo)
   );

   // mirroring by direction flag and by reverse-once mode
   always_comb begin
      p_mir = p_ff;
      if (flip_ff) begin
         p_mir = ONE_Q - p_mir;
      end
      if (mode_ff == MODE_REV_ONCE) begin
         p_mir = ONE_Q - p_mir;
      end
      q_mir = ONE_Q - p_mir;
      use_q = (easing_ff == EASE_OUT) || (easing_ff == EASE_BOTH && p_mir >= HALF_Q);
   end

   // easing from the squared term
   assign sq_hi = mul_p[2*FRAC_BITS:FRAC_BITS];
   assign sq_lo = mul_p[2*FRAC_BITS-1:FRAC_BITS-1];

   always_comb begin
      case (easing_ff)
         EASE_IN:    eased = sq_hi;
         EASE_OUT:   eased = ONE_Q - sq_hi;
         EASE_BOTH:  eased = (p_ff < HALF_Q) ? sq_lo : (ONE_Q - sq_lo);
         EASE_CONST: eased = '0;
         default:    eased = p_ff;
      endcase
   end

   assign delta = {end_ff[VALUE_BITS-1], end_ff} - {start_ff[VALUE_BITS-1], start_ff};

   // operand select for the shared multiplier
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      if (state_ff == S_SQ) begin
         mul_en = 1'b1;
         mul_a  = {{(MW-FRAC_BITS-1){1'b0}}, (use_q ? q_mir : p_mir)};
         mul_b  = {{(MW-FRAC_BITS-1){1'b0}}, (use_q ? q_mir : p_mir)};
      end else if (state_ff == S_LERP) begin
         mul_en = 1'b1;
         mul_a  = {{(MW-FRAC_BITS-1){1'b0}}, e_ff};
         mul_b  = {{(MW-VALUE_BITS-1){delta[VALUE_BITS]}}, delta};
      end
   end

   etg_mul #(.WIDTH(MW)) u_mul (
      .clock   (clock),
      .en      (mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p)
   );

   // round half up before the fraction is dropped
   assign rnd = mul_p + PW'(HALF_Q);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         end_ff    <= '0;
         dur_ff    <= DURATION_RESET;
         easing_ff <= EASE_LINEAR;
         mode_ff   <= MODE_ONCE;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_VALUE_START: start_ff  <= csr_wdata;
            CSR_VALUE_END:   end_ff    <= csr_wdata;
            CSR_DURATION:    dur_ff    <= csr_wdata;
            CSR_EASING:      easing_ff <= csr_wdata[2:0];
            CSR_MODE:        mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // sequencer, tween state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_IDLE;
         flip_ff       <= 1'b0;
         pass_start_ff <= '0;
         pause_time_ff <= '0;
         held_ff       <= '0;
         fin_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  fin_ff   <= tick_fin;
                  state_ff <= accept_state;
                  unique case (req_payload.opcode)
                     OP_TICK: begin
                        if (phase_ff == PH_PLAY) begin
                           if (over) begin
                              p_ff <= '0;
                              if (mode_ff == MODE_LOOP) begin
                                 pass_start_ff <= req_payload.now_ms;
                              end else if (mode_ff == MODE_FLIP) begin
                                 pass_start_ff <= req_payload.now_ms;
                                 flip_ff       <= !flip_ff;
                              end else begin
                                 held_ff  <= (mode_ff == MODE_REV_ONCE) ? start_ff : end_ff;
                                 phase_ff <= PH_IDLE;
                              end
                           end else if (dur_ff == '0) begin
                              p_ff <= ONE_Q;
                           end
                        end
                     end
                     OP_PLAY: begin
                        pass_start_ff <= req_payload.now_ms;
                        phase_ff      <= PH_PLAY;
                        flip_ff       <= 1'b0;
                     end
                     OP_STOP: begin
                        phase_ff <= PH_IDLE;
                     end
                     OP_PAUSE: begin
                        if (phase_ff == PH_PLAY) begin
                           pause_time_ff <= req_payload.now_ms;
                           phase_ff      <= PH_PAUSE;
                        end
                     end
                     OP_RESUME: begin
                        if (phase_ff == PH_PAUSE) begin
                           phase_ff      <= PH_PLAY;
                           pass_start_ff <= pass_start_ff + (req_payload.now_ms - pause_time_ff);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV: begin
               if (div_done) begin
                  p_ff     <= div_quo;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               p_ff     <= p_mir;
               state_ff <= S_EASE;
            end
            S_EASE: begin
               e_ff     <= eased;
               state_ff <= S_LERP;
            end
            S_LERP: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               held_ff  <= start_ff + rnd[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff                 <= 1'b1;
                  rsp_payload_ff.current_value <= held_ff;
                  rsp_payload_ff.run_state     <= phase_ff;
                  rsp_payload_ff.finished      <= fin_ff;
                  rsp_payload_ff.reversed      <= flip_ff;
                  state_ff                     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[src/etg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etg_checker
// Port-level checks of the tween generator, bound to the top level.
// ----------------------------------------------------------------------------
module etg_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input etg_pkg::rsp_payload_type rsp_payload
);
   import etg_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // one request at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // a finished pass always reports idle
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.finished |-> rsp_payload.run_state == PH_IDLE)
      else $error("finished response not idle");

   // run state never shows the unused code
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.run_state != 2'd3)
      else $error("bad run state code");

   // reset empties the response register
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind eased_tween_generator_top etg_checker u_etg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
